@@ rtl/sstfe_pkg.sv @@
// package for the seven-segment time frame encoder
// types, frame constants and digit/segment functions; no dependencies
package sstfe_pkg;

	localparam int unsigned FrameLen = 12;
	localparam int unsigned IdxW     = 4;
	localparam int unsigned QDepth   = 2;

	typedef logic [IdxW-1:0] idx_t;

	localparam idx_t LastIdx = idx_t'(FrameLen - 1);

	// command bytes of the frame
	localparam logic [7:0] CmdMode   = 8'h03;
	localparam logic [7:0] CmdWrite  = 8'h44;
	localparam logic [7:0] CmdCtrl   = 8'h82;
	localparam logic [7:0] AddrDig0  = 8'hC0;
	localparam logic [7:0] AddrDig1  = 8'hC2;
	localparam logic [7:0] AddrDig2  = 8'hC4;
	localparam logic [7:0] AddrDig3  = 8'hC6;
	localparam logic [7:0] CmdDispOn = 8'h8A;
	localparam logic [7:0] ColonBit  = 8'h80;
	localparam logic [7:0] SegBlank  = 8'h00;

	// byte positions in the frame
	localparam idx_t PosMode   = 4'd0;
	localparam idx_t PosWrite  = 4'd1;
	localparam idx_t PosCtrl   = 4'd2;
	localparam idx_t PosAddr0  = 4'd3;
	localparam idx_t PosSeg0   = 4'd4;
	localparam idx_t PosAddr1  = 4'd5;
	localparam idx_t PosSeg1   = 4'd6;
	localparam idx_t PosAddr2  = 4'd7;
	localparam idx_t PosSeg2   = 4'd8;
	localparam idx_t PosAddr3  = 4'd9;
	localparam idx_t PosSeg3   = 4'd10;
	localparam idx_t PosDispOn = 4'd11;

	typedef struct packed {
		logic [7:0] hours;
		logic [7:0] minutes;
		logic       colon;
	} time_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_start;
		logic       frame_end;
		logic       last_byte;
	} byte_t;

	// four segment bytes of one frame: hour tens, hour ones, minute tens, minute ones
	typedef struct packed {
		logic [7:0] h_tens;
		logic [7:0] h_ones;
		logic [7:0] m_tens;
		logic [7:0] m_ones;
	} segs_t;

	// common-cathode code, bit 0 = segment a; digits above nine are blank
	function automatic logic [7:0] digit_to_seg(input logic [4:0] d);
		logic [7:0] code;
		unique case (d)
			5'd0:    code = 8'h3F;
			5'd1:    code = 8'h06;
			5'd2:    code = 8'h5B;
			5'd3:    code = 8'h4F;
			5'd4:    code = 8'h66;
			5'd5:    code = 8'h6D;
			5'd6:    code = 8'h7D;
			5'd7:    code = 8'h07;
			5'd8:    code = 8'h7F;
			5'd9:    code = 8'h6F;
			default: code = SegBlank;
		endcase
		return code;
	endfunction

	// tens digit by reciprocal multiply, exact for all 8-bit values
	function automatic logic [4:0] tens_of(input logic [7:0] v);
		logic [15:0] prod;
		prod = v * 16'd205;
		return prod[15:11];
	endfunction

	function automatic logic [4:0] ones_of(input logic [7:0] v);
		logic [7:0] tens10;
		logic [7:0] rem;
		tens10 = {3'b000, tens_of(v)} * 8'd10;
		rem    = v - tens10;
		return {1'b0, rem[3:0]};
	endfunction

	// byte at a frame position, with its strobe marks
	function automatic byte_t frame_byte(input idx_t idx, input segs_t s);
		byte_t b;
		b.last_byte   = (idx == LastIdx);
		b.frame_start = 1'b1;
		b.frame_end   = 1'b1;
		unique case (idx)
			PosMode:   b.tx_byte = CmdMode;
			PosWrite:  b.tx_byte = CmdWrite;
			PosCtrl:   b.tx_byte = CmdCtrl;
			PosAddr0: begin
				b.tx_byte   = AddrDig0;
				b.frame_end = 1'b0;
			end
			PosAddr1: begin
				b.tx_byte   = AddrDig1;
				b.frame_end = 1'b0;
			end
			PosAddr2: begin
				b.tx_byte   = AddrDig2;
				b.frame_end = 1'b0;
			end
			PosAddr3: begin
				b.tx_byte   = AddrDig3;
				b.frame_end = 1'b0;
			end
			PosSeg0: begin
				b.tx_byte     = s.h_tens;
				b.frame_start = 1'b0;
			end
			PosSeg1: begin
				b.tx_byte     = s.h_ones;
				b.frame_start = 1'b0;
			end
			PosSeg2: begin
				b.tx_byte     = s.m_tens;
				b.frame_start = 1'b0;
			end
			PosSeg3: begin
				b.tx_byte     = s.m_ones;
				b.frame_start = 1'b0;
			end
			PosDispOn: b.tx_byte = CmdDispOn;
			default:   b.tx_byte = SegBlank;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/sstfe_front.sv @@
// front stage: accepts time transactions and encodes the four segment bytes
// depends on sstfe_pkg
module sstfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              time_valid,
	output logic              time_ready,
	input  sstfe_pkg::time_t  time_data,
	output logic              push_valid,
	input  logic              push_ready,
	output sstfe_pkg::segs_t  push_data
);

	logic             valid_s1;
	sstfe_pkg::segs_t segs_s1;
	sstfe_pkg::segs_t segs_d;

	// digit split and segment lookup
	always_comb begin
		segs_d.h_tens = sstfe_pkg::digit_to_seg(sstfe_pkg::tens_of(time_data.hours));
		segs_d.h_ones = sstfe_pkg::digit_to_seg(sstfe_pkg::ones_of(time_data.hours))
			| (time_data.colon ? sstfe_pkg::ColonBit : sstfe_pkg::SegBlank);
		segs_d.m_tens = sstfe_pkg::digit_to_seg(sstfe_pkg::tens_of(time_data.minutes));
		segs_d.m_ones = sstfe_pkg::digit_to_seg(sstfe_pkg::ones_of(time_data.minutes));
	end

	assign time_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = segs_s1;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (time_ready) begin
			valid_s1 <= time_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (time_valid && time_ready) begin
			segs_s1 <= segs_d;
		end
	end

endmodule

@@ rtl/sstfe_queue.sv @@
// two-entry queue of encoded frames between front and back
// depends on sstfe_pkg
module sstfe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  sstfe_pkg::segs_t  push_data,
	output logic              pop_valid,
	input  logic              pop,
	output sstfe_pkg::segs_t  pop_data
);

	localparam int unsigned PtrW = $clog2(sstfe_pkg::QDepth);

	sstfe_pkg::segs_t      entries_q [sstfe_pkg::QDepth];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [PtrW:0]         count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != (PtrW+1)'(sstfe_pkg::QDepth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/sstfe_back.sv @@
// back stage: walks the twelve frame positions and drives the output register
// depends on sstfe_pkg
module sstfe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop,
	input  sstfe_pkg::segs_t  pop_data,
	output logic              byte_valid,
	input  logic              byte_ready,
	output sstfe_pkg::byte_t  byte_data
);

	sstfe_pkg::idx_t  idx_q;
	logic             out_valid_q;
	sstfe_pkg::byte_t out_q;
	logic             load;

	assign load       = pop_valid && (!out_valid_q || byte_ready);
	assign pop        = load && (idx_q == sstfe_pkg::LastIdx);
	assign byte_valid = out_valid_q;
	assign byte_data  = out_q;

	// position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			idx_q       <= (idx_q == sstfe_pkg::LastIdx) ? '0 : idx_q + 1'b1;
			out_valid_q <= 1'b1;
		end else if (byte_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output byte register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= sstfe_pkg::frame_byte(idx_q, pop_data);
		end
	end

endmodule

@@ rtl/seven_segment_time_frame_encoder_unit.sv @@
// seven-segment time frame encoder: one time transaction gives a 12-byte driver frame
// the first byte of a frame goes through the front stage register, a queue entry and the back output register
// output: twelve bytes per transaction, one byte per cycle from the back output register while byte_ready is high
// a two-entry frame queue lets the front take new transactions while a frame streams out
// reset clears the stage valid, queue pointers, byte counter and output valid
// depends on sstfe_pkg, sstfe_front, sstfe_queue, sstfe_back
module seven_segment_time_frame_encoder_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              time_valid,
	output logic              time_ready,
	input  sstfe_pkg::time_t  time_data,
	output logic              byte_valid,
	input  logic              byte_ready,
	output sstfe_pkg::byte_t  byte_data
);

	logic             push_valid;
	logic             push_ready;
	sstfe_pkg::segs_t push_data;
	logic             pop_valid;
	logic             pop;
	sstfe_pkg::segs_t pop_data;

	// encode
	sstfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.time_valid (time_valid),
		.time_ready (time_ready),
		.time_data  (time_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decouple
	sstfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	// sequence bytes
	sstfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data)
	);

endmodule

@@ test/seven_segment_time_frame_encoder_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench for seven_segment_time_frame_encoder_unit: directed time values, then random ones
// every accepted time transaction is predicted as a 12-byte frame and checked byte by byte
// depends on sstfe_pkg and the encoder rtl
module seven_segment_time_frame_encoder_unit_tb;

	localparam int unsigned RandItems   = 320;
	localparam int unsigned LongHold    = 80;
	localparam int unsigned DrainCycles = 40;

	// one directed row: segment bytes are typed in only where they are obvious
	typedef struct {
		sstfe_pkg::time_t t;
		bit               typed;
		sstfe_pkg::segs_t segs;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             time_valid;
	logic             time_ready;
	sstfe_pkg::time_t time_data;
	logic             byte_valid;
	logic             byte_ready;
	sstfe_pkg::byte_t byte_data;

	sstfe_pkg::byte_t pending_bytes [$];
	int unsigned      mismatch_count = 0;
	int unsigned      bytes_seen     = 0;
	bit               calm           = 1'b0;
	bit               fill           = 1'b0;
	bit               hold_req       = 1'b0;

	// common-cathode glyphs, bit 0 = segment a
	logic [7:0] glyph [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
		8'h7D - 8'h10, 8'h7D, 8'h07, 8'h7F, 8'h6F};

	stim_row_t dir_rows [18] = '{
		'{'{8'd0,   8'd0,   1'b0}, 1'b1, '{8'h3F, 8'h3F, 8'h3F, 8'h3F}},
		'{'{8'd0,   8'd0,   1'b1}, 1'b1, '{8'h3F, 8'hBF, 8'h3F, 8'h3F}},
		'{'{8'd99,  8'd99,  1'b0}, 1'b1, '{8'h6F, 8'h6F, 8'h6F, 8'h6F}},
		'{'{8'd255, 8'd255, 1'b1}, 1'b1, '{8'h00, 8'hED, 8'h00, 8'h6D}},
		'{'{8'd255, 8'd255, 1'b0}, 1'b1, '{8'h00, 8'h6D, 8'h00, 8'h6D}},
		'{'{8'd100, 8'd100, 1'b1}, 1'b1, '{8'h00, 8'hBF, 8'h00, 8'h3F}},
		'{'{8'd12,  8'd34,  1'b1}, 1'b1, '{8'h06, 8'hDB, 8'h4F, 8'h66}},
		'{'{8'd56,  8'd78,  1'b0}, 1'b1, '{8'h6D, 8'h7D, 8'h07, 8'h7F}},
		'{'{8'd90,  8'd9,   1'b1}, 1'b1, '{8'h6F, 8'hBF, 8'h3F, 8'h6F}},
		'{'{8'd0,   8'd255, 1'b0}, 1'b1, '{8'h3F, 8'h3F, 8'h00, 8'h6D}},
		'{'{8'd255, 8'd0,   1'b1}, 1'b1, '{8'h00, 8'hED, 8'h3F, 8'h3F}},
		'{'{8'd99,  8'd59,  1'b1}, 1'b0, '0},
		'{'{8'd23,  8'd59,  1'b1}, 1'b0, '0},
		'{'{8'd109, 8'd250, 1'b0}, 1'b0, '0},
		'{'{8'd128, 8'd127, 1'b1}, 1'b0, '0},
		'{'{8'd170, 8'd85,  1'b0}, 1'b0, '0},
		'{'{8'd85,  8'd170, 1'b1}, 1'b0, '0},
		'{'{8'd19,  8'd101, 1'b0}, 1'b0, '0}
	};

	seven_segment_time_frame_encoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.time_valid (time_valid),
		.time_ready (time_ready),
		.time_data  (time_data),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data)
	);

	// clock, 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// tens digits above nine are blank
	function automatic logic [7:0] digit_glyph(input int unsigned d);
		if (d > 9)
			return sstfe_pkg::SegBlank;
		return glyph[d];
	endfunction

	// segment bytes shown for one time value
	function automatic sstfe_pkg::segs_t segs_for(input sstfe_pkg::time_t t);
		sstfe_pkg::segs_t s;
		s.h_tens = digit_glyph(t.hours / 10);
		s.h_ones = digit_glyph(t.hours % 10)
			| (t.colon ? sstfe_pkg::ColonBit : sstfe_pkg::SegBlank);
		s.m_tens = digit_glyph(t.minutes / 10);
		s.m_ones = digit_glyph(t.minutes % 10);
		return s;
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic st, input logic en,
			input logic last);
		sstfe_pkg::byte_t x;
		x.tx_byte     = b;
		x.frame_start = st;
		x.frame_end   = en;
		x.last_byte   = last;
		pending_bytes.push_back(x);
	endfunction

	// full frame: three commands, four address/segment pairs, display on
	function automatic void queue_frame(input sstfe_pkg::segs_t s);
		logic [7:0] addr [4];
		logic [7:0] seg [4];
		addr = '{sstfe_pkg::AddrDig0, sstfe_pkg::AddrDig1, sstfe_pkg::AddrDig2,
			sstfe_pkg::AddrDig3};
		seg  = '{s.h_tens, s.h_ones, s.m_tens, s.m_ones};
		push_byte(sstfe_pkg::CmdMode, 1'b1, 1'b1, 1'b0);
		push_byte(sstfe_pkg::CmdWrite, 1'b1, 1'b1, 1'b0);
		push_byte(sstfe_pkg::CmdCtrl, 1'b1, 1'b1, 1'b0);
		for (int i = 0; i < 4; i++) begin
			push_byte(addr[i], 1'b1, 1'b0, 1'b0);
			push_byte(seg[i], 1'b0, 1'b1, 1'b0);
		end
		push_byte(sstfe_pkg::CmdDispOn, 1'b1, 1'b1, 1'b1);
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// compare one received byte with the oldest pending one
	task automatic check_byte(input sstfe_pkg::byte_t got);
		sstfe_pkg::byte_t want;
		string where;
		where = $sformatf("frame %0d byte %0d", bytes_seen / sstfe_pkg::FrameLen,
			bytes_seen % sstfe_pkg::FrameLen);
		bytes_seen++;
		if (pending_bytes.size() == 0) begin
			flag_mismatch($sformatf("%s: got %02h with nothing pending", where, got.tx_byte));
			return;
		end
		want = pending_bytes.pop_front();
		if (got.tx_byte !== want.tx_byte)
			flag_mismatch($sformatf("%s: tx_byte %02h, want %02h", where, got.tx_byte,
				want.tx_byte));
		if (got.frame_start !== want.frame_start)
			flag_mismatch($sformatf("%s: frame_start %b, want %b", where, got.frame_start,
				want.frame_start));
		if (got.frame_end !== want.frame_end)
			flag_mismatch($sformatf("%s: frame_end %b, want %b", where, got.frame_end,
				want.frame_end));
		if (got.last_byte !== want.last_byte)
			flag_mismatch($sformatf("%s: last_byte %b, want %b", where, got.last_byte,
				want.last_byte));
	endtask

	// sender gaps: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (calm || fill || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// offer one time transaction, predict its frame once accepted
	task automatic send_time(input sstfe_pkg::time_t t, input sstfe_pkg::segs_t s);
		int unsigned gap;
		time_data  <= t;
		time_valid <= 1'b1;
		do @(posedge clk); while (!time_ready);
		queue_frame(s);
		gap = pick_gap();
		if (gap > 0) begin
			time_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for every pending byte
	task automatic wait_drained();
		time_valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	// random time: mostly clock-like, some two-digit, some full range
	function automatic sstfe_pkg::time_t rand_time();
		sstfe_pkg::time_t t;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) begin
			t.hours   = 8'($urandom_range(23));
			t.minutes = 8'($urandom_range(59));
		end else if (r < 80) begin
			t.hours   = 8'($urandom_range(99));
			t.minutes = 8'($urandom_range(99));
		end else begin
			t.hours   = 8'($urandom_range(255));
			t.minutes = 8'($urandom_range(255));
		end
		t.colon = 1'($urandom_range(1));
		return t;
	endfunction

	// stimulus
	initial begin
		sstfe_pkg::time_t t;
		arst_n     = 1'b0;
		time_valid = 1'b0;
		time_data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (dir_rows[i])
			send_time(dir_rows[i].t,
				dir_rows[i].typed ? dir_rows[i].segs : segs_for(dir_rows[i].t));
		wait_drained();

		// random part with a calm stretch, a fill under a long hold-off and a full pause
		for (int n = 0; n < RandItems; n++) begin
			calm = (n >= 100 && n < 150);
			if (n == 160) begin
				fill     = 1'b1;
				hold_req = 1'b1;
			end
			if (n == 190)
				fill = 1'b0;
			if (n == 220)
				wait_drained();
			t = rand_time();
			send_time(t, segs_for(t));
		end
		wait_drained();
		repeat (DrainCycles) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// receiver: checks bytes and drives ready with random stalls
	initial begin
		int unsigned stall_left;
		int unsigned r;
		stall_left = 0;
		byte_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (byte_valid && byte_ready)
				check_byte(byte_data);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LongHold;
			end
			r = $urandom_range(99);
			if (stall_left > 0) begin
				byte_ready <= 1'b0;
				stall_left--;
			end else if (calm || r < 65) begin
				byte_ready <= 1'b1;
			end else begin
				byte_ready <= 1'b0;
				stall_left = (r < 95) ? $urandom_range(2, 0) : $urandom_range(24, 8);
			end
		end
	end

	// run limit
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
